### hdl/lbps_pkg.sv
// Shared types, codes and the colour palette for the LED blink pattern sequencer.
// No dependencies; used by the top level and its checker.
`default_nettype none

package lbps_pkg;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned EXTRA_W = 8;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned LEVEL_W = 8;

  // Colour kinds that have a palette entry.
  localparam logic [KIND_W-1:0] KIND_LAYER    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WIRELESS = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BATTERY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TOUCH_ON = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOUCH_OFF = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
  } rgb_t;

  // Palette lookup; kinds without an entry give black.
  function automatic rgb_t palette(input logic [KIND_W-1:0] kind);
    rgb_t c;
    c = '0;
    unique case (kind)
      KIND_LAYER:     c.green = 8'd10;
      KIND_WIRELESS:  c.blue  = 8'd10;
      KIND_BATTERY:   c.red   = 8'd10;
      KIND_TOUCH_ON:  c.red   = 8'd5;
      KIND_TOUCH_OFF: c.green = 8'd3;
      default:        c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/led_blink_pattern_sequencer_unit.sv
// LED blink pattern sequencer: request queue, blink timing and palette output.
// Depends on lbps_pkg; checked by lbps_checker, which binds to this module.
//
// Path: a word accepted on the input passes through the input register and then
// the result register before it appears on the output.
// Throughput: one word per cycle while out_tready allows, set by the single pass from
// input register to result register; both registers hold a word each, so the input
// keeps flowing for one extra word while a result waits on out_tready.
// Reset (rst_n low, synchronous): queue empty, pattern idle, both stages empty.
`default_nettype none

module led_blink_pattern_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned LED_COUNT   = 4,
  // Derived widths.
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned ENTRY_W = LED_COUNT + lbps_pkg::KIND_W + lbps_pkg::EXTRA_W +
                                    2 * lbps_pkg::MS_W,
  localparam int unsigned IN_W   = ((ENTRY_W + 7) / 8) * 8,
  localparam int unsigned OUT_RAW_W = LED_COUNT + 3 * lbps_pkg::LEVEL_W + 2 + CNT_W,
  localparam int unsigned OUT_W  = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Input channel.
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  // tdata, lowest bit up: req_led_mask, req_color_kind, req_extra_blinks,
  // req_on_ms, req_off_ms, zero fill.
  input  wire logic [IN_W-1:0]  in_tdata,
  // tuser: func (0 = millisecond tick, 1 = blink request).
  input  wire logic             in_tuser,
  // Result channel.
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  // tdata, lowest bit up: lit_mask, red, green, blue, phase, queue_level, zero fill.
  output      logic [OUT_W-1:0] out_tdata,
  // tuser: dropped (request lost because the queue was full).
  output      logic             out_tuser
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned MS_W  = lbps_pkg::MS_W;
  localparam int unsigned KW    = lbps_pkg::KIND_W;
  localparam int unsigned EW    = lbps_pkg::EXTRA_W;

  // Bit positions of the request fields inside a queue entry.
  localparam int unsigned KIND_LO  = LED_COUNT;
  localparam int unsigned EXTRA_LO = KIND_LO + KW;
  localparam int unsigned ON_LO    = EXTRA_LO + EW;
  localparam int unsigned OFF_LO   = ON_LO + MS_W;

  // ---------------------------------------------------------------------------
  // Handshake. The item register is emptied whenever the result register is
  // free or is being drained this cycle; only then is the item processed and
  // the sequencer state advanced.
  // ---------------------------------------------------------------------------
  logic               item_valid_r;
  logic               item_func_r;
  logic [ENTRY_W-1:0] item_data_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_drop_r;
  logic               do_item;

  assign do_item   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || do_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_func_r <= in_tuser;
      item_data_r <= in_tdata[ENTRY_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state.
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [LED_COUNT-1:0] act_mask_r, act_mask_nxt;
  logic [KW-1:0]        act_kind_r, act_kind_nxt;
  logic [MS_W-1:0]      act_on_r, act_on_nxt;
  logic [MS_W-1:0]      act_off_r, act_off_nxt;
  lbps_pkg::phase_t     phase_r, phase_nxt;
  logic [MS_W-1:0]      elapsed_r, elapsed_nxt;
  logic [EW-1:0]        blinks_r, blinks_nxt;

  // The queue is a memory with one write and one registered read port. The
  // read port always fetches the entry at the next head pointer, so the head
  // of the queue is ready in head_data_r when the following word arrives. A
  // write to that very entry in the same cycle is forwarded.
  logic [ENTRY_W-1:0]   queue_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]   head_data_r;
  logic                 push, drop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[tail_r] <= item_data_r;
    end
    if (push && (tail_r == head_nxt)) begin
      head_data_r <= item_data_r;
    end else begin
      head_data_r <= queue_mem[head_nxt];
    end
  end

  // Next state. A request only touches the queue; a tick pops a waiting
  // request (which restarts the pattern) or else ages the running pattern,
  // and then at most one phase change is made.
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    act_mask_nxt = act_mask_r;
    act_kind_nxt = act_kind_r;
    act_on_nxt   = act_on_r;
    act_off_nxt  = act_off_r;
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    blinks_nxt   = blinks_r;
    push         = 1'b0;
    drop         = 1'b0;

    if (do_item) begin
      if (item_func_r == lbps_pkg::FUNC_REQ) begin
        if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          drop = 1'b1;
        end else begin
          push      = 1'b1;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (count_r != '0) begin
          head_nxt     = ptr_inc(head_r);
          count_nxt    = count_r - CNT_W'(1);
          act_mask_nxt = head_data_r[LED_COUNT-1:0];
          act_kind_nxt = head_data_r[KIND_LO +: KW];
          act_on_nxt   = head_data_r[ON_LO +: MS_W];
          act_off_nxt  = head_data_r[OFF_LO +: MS_W];
          blinks_nxt   = head_data_r[EXTRA_LO +: EW];
          phase_nxt    = lbps_pkg::PH_ON;
          elapsed_nxt  = '0;
        end else if (phase_r != lbps_pkg::PH_IDLE && elapsed_r != '1) begin
          elapsed_nxt = elapsed_r + MS_W'(1);
        end

        unique case (phase_nxt)
          lbps_pkg::PH_ON: begin
            if (elapsed_nxt >= act_on_nxt) begin
              phase_nxt   = lbps_pkg::PH_OFF;
              elapsed_nxt = '0;
            end
          end
          lbps_pkg::PH_OFF: begin
            if (elapsed_nxt >= act_off_nxt) begin
              if (blinks_nxt != '0) begin
                blinks_nxt = blinks_nxt - EW'(1);
                phase_nxt  = lbps_pkg::PH_ON;
              end else begin
                phase_nxt  = lbps_pkg::PH_IDLE;
              end
              elapsed_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      act_mask_r <= '0;
      act_kind_r <= '0;
      act_on_r   <= '0;
      act_off_r  <= '0;
      phase_r    <= lbps_pkg::PH_IDLE;
      elapsed_r  <= '0;
      blinks_r   <= '0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      act_mask_r <= act_mask_nxt;
      act_kind_r <= act_kind_nxt;
      act_on_r   <= act_on_nxt;
      act_off_r  <= act_off_nxt;
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
      blinks_r   <= blinks_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word: the display after this item. LEDs and colour show only
  // during an on period.
  // ---------------------------------------------------------------------------
  logic [LED_COUNT-1:0] lit_nxt;
  lbps_pkg::rgb_t       rgb_nxt;
  logic [OUT_W-1:0]     out_data_nxt;

  always_comb begin
    if (phase_nxt == lbps_pkg::PH_ON) begin
      lit_nxt = act_mask_nxt;
      rgb_nxt = lbps_pkg::palette(act_kind_nxt);
    end else begin
      lit_nxt = '0;
      rgb_nxt = '0;
    end
    out_data_nxt = OUT_W'({count_nxt, phase_nxt, rgb_nxt.blue, rgb_nxt.green,
                           rgb_nxt.red, lit_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_item) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_item) begin
      out_data_r <= out_data_nxt;
      out_drop_r <= drop;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_drop_r;

endmodule

`default_nettype wire

### hdl/lbps_checker.sv
// Port-level checks for the LED blink pattern sequencer, bound to its top level.
// Depends on lbps_pkg and on led_blink_pattern_sequencer_unit for the bind.
`default_nettype none

module lbps_checker #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned LED_COUNT   = 4,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned OUT_W       = 40
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tuser
);

  localparam int unsigned LV    = lbps_pkg::LEVEL_W;
  localparam int unsigned PH_LO = LED_COUNT + 3 * LV;
  localparam int unsigned LV_LO = PH_LO + 2;

  logic [LED_COUNT-1:0] lit;
  logic [3*LV-1:0]      colour;
  logic [1:0]           ph;
  logic [CNT_W-1:0]     level;

  assign lit    = out_tdata[LED_COUNT-1:0];
  assign colour = out_tdata[LED_COUNT +: 3*LV];
  assign ph     = out_tdata[PH_LO +: 2];
  assign level  = out_tdata[LV_LO +: CNT_W];

  // A result waiting on the sink keeps its word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A request is only lost when the queue is full.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> level == CNT_W'(QUEUE_DEPTH))
    else $error("request dropped with room in queue");

  // The queue level never exceeds the depth.
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> level <= CNT_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  // LEDs and colour stay dark outside an on period.
  a_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ph != lbps_pkg::PH_ON |-> lit == '0 && colour == '0)
    else $error("LEDs lit outside an on period");

endmodule

bind led_blink_pattern_sequencer_unit lbps_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .LED_COUNT  (LED_COUNT),
  .CNT_W      (CNT_W),
  .OUT_W      (OUT_W)
) u_lbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

### verif/tb_led_blink_pattern_sequencer_unit.sv
// Self-checking testbench for led_blink_pattern_sequencer_unit.
// Drives ticks and blink requests; compares every result word with its own prediction
// of the queue and blink timing or a directed value. Depends on lbps_pkg and the DUT.

module tb_led_blink_pattern_sequencer_unit;

  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned QDEPTH         = 16;
  localparam int unsigned ELAPSED_CAP    = 65535;
  localparam int unsigned RANDOM_WORDS   = 1550;
  // Two pipeline stages in the block; a few spare cycles catch stray words.
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  // A blink request as it sits in tdata: mask in the lowest bits, off time on top.
  typedef struct packed {
    logic [lbps_pkg::MS_W-1:0]    off_ms;
    logic [lbps_pkg::MS_W-1:0]    on_ms;
    logic [lbps_pkg::EXTRA_W-1:0] extra;
    logic [lbps_pkg::KIND_W-1:0]  kind;
    logic [3:0]                   mask;
  } blink_req_t;

  // One result: dropped travels on tuser, the rest on tdata from lit upwards.
  typedef struct packed {
    logic              dropped;
    logic [4:0]        level;
    lbps_pkg::phase_t  phase;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [3:0]        lit;
  } display_t;

  // A word to send; where typed is set, want replaces the prediction.
  typedef struct packed {
    logic       func;
    blink_req_t rq;
    bit         typed;
    display_t   want;
  } stim_t;

  typedef struct packed {
    logic [7:0] count;
    stim_t      s;
  } dir_row_t;

  localparam int unsigned REQ_W   = $bits(blink_req_t);
  localparam int unsigned IN_W    = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned DISP_W  = $bits(display_t);
  localparam int unsigned OUT_W   = ((DISP_W - 1 + 7) / 8) * 8;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata  = '0;
  logic             in_tuser  = lbps_pkg::FUNC_TICK;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  always #(HALF_PERIOD) clk = ~clk;

  led_blink_pattern_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Prediction. The testbench keeps its own copy of the request queue and of
  // the pattern being shown, and steps it once for every word the block takes.
  // ---------------------------------------------------------------------------
  blink_req_t        pending_reqs [QDEPTH];
  int unsigned       pend_head   = 0;
  int unsigned       pend_count  = 0;
  blink_req_t        showing     = '0;
  lbps_pkg::phase_t  cur_phase   = lbps_pkg::PH_IDLE;
  int unsigned       elapsed     = 0;
  int unsigned       blinks_left = 0;

  display_t    expected_displays [$];
  stim_t       words_to_send [$];
  dir_row_t    dir_rows [$];
  stim_t       offered = '0;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;

  task automatic step_sequencer(input logic func, input blink_req_t rq,
                                output display_t d);
    d = '0;
    d.phase = lbps_pkg::PH_IDLE;
    if (func == lbps_pkg::FUNC_REQ) begin
      // A request only touches the queue; the pattern holds still.
      if (pend_count >= QDEPTH) begin
        d.dropped = 1'b1;
      end else begin
        pending_reqs[(pend_head + pend_count) % QDEPTH] = rq;
        pend_count++;
      end
    end else begin
      // A waiting request pre-empts whatever is showing, else time moves on.
      if (pend_count > 0) begin
        showing     = pending_reqs[pend_head];
        pend_head   = (pend_head + 1) % QDEPTH;
        pend_count--;
        cur_phase   = lbps_pkg::PH_ON;
        elapsed     = 0;
        blinks_left = 32'(showing.extra);
      end else if (cur_phase != lbps_pkg::PH_IDLE && elapsed < ELAPSED_CAP) begin
        elapsed++;
      end
      // At most one phase change per tick.
      if (cur_phase == lbps_pkg::PH_ON) begin
        if (elapsed >= showing.on_ms) begin
          cur_phase = lbps_pkg::PH_OFF;
          elapsed   = 0;
        end
      end else if (cur_phase == lbps_pkg::PH_OFF) begin
        if (elapsed >= showing.off_ms) begin
          if (blinks_left > 0) begin
            blinks_left--;
            cur_phase = lbps_pkg::PH_ON;
          end else begin
            cur_phase = lbps_pkg::PH_IDLE;
          end
          elapsed = 0;
        end
      end
    end
    if (cur_phase == lbps_pkg::PH_ON) begin
      d.lit = showing.mask;
      case (showing.kind)
        lbps_pkg::KIND_LAYER:     d.green = 8'd10;
        lbps_pkg::KIND_WIRELESS:  d.blue  = 8'd10;
        lbps_pkg::KIND_BATTERY:   d.red   = 8'd10;
        lbps_pkg::KIND_TOUCH_ON:  d.red   = 8'd5;
        lbps_pkg::KIND_TOUCH_OFF: d.green = 8'd3;
        default:                  ;
      endcase
    end
    d.phase = cur_phase;
    d.level = pend_count[4:0];
  endtask

  // Every word accepted on the input gets its expected result queued here. The
  // bus values are sampled before the edge, so this sees what the block takes.
  always @(posedge clk) begin : predict_on_accept
    display_t d;
    if (rst_n && in_tvalid && in_tready) begin
      step_sequencer(in_tuser, in_tdata[REQ_W-1:0], d);
      expected_displays.push_back(offered.typed ? offered.want : d);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Every result word taken from the output is held against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_on_accept
    display_t got;
    display_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = {out_tuser, out_tdata[DISP_W-2:0]};
      if (expected_displays.size() == 0) begin
        $error("result word arrived with no prediction waiting");
        mismatches++;
      end else begin
        want = expected_displays.pop_front();
        check_field("lit_mask",    32'(want.lit),     32'(got.lit));
        check_field("red",         32'(want.red),     32'(got.red));
        check_field("green",       32'(want.green),   32'(got.green));
        check_field("blue",        32'(want.blue),    32'(got.blue));
        check_field("phase",       32'(want.phase),   32'(got.phase));
        check_field("queue_level", 32'(want.level),   32'(got.level));
        check_field("dropped",     32'(want.dropped), 32'(got.dropped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------
  function automatic blink_req_t breq(input int unsigned mask, input int unsigned kind,
                                      input int unsigned extra, input int unsigned on_ms,
                                      input int unsigned off_ms);
    blink_req_t rq;
    rq.mask   = mask[3:0];
    rq.kind   = kind[lbps_pkg::KIND_W-1:0];
    rq.extra  = extra[lbps_pkg::EXTRA_W-1:0];
    rq.on_ms  = on_ms[lbps_pkg::MS_W-1:0];
    rq.off_ms = off_ms[lbps_pkg::MS_W-1:0];
    return rq;
  endfunction

  function automatic display_t disp(input int unsigned lit, input int unsigned red,
                                    input int unsigned green, input int unsigned blue,
                                    input lbps_pkg::phase_t ph, input int unsigned level,
                                    input int unsigned dropped);
    display_t d;
    d.lit     = lit[3:0];
    d.red     = red[7:0];
    d.green   = green[7:0];
    d.blue    = blue[7:0];
    d.phase   = ph;
    d.level   = level[4:0];
    d.dropped = dropped[0];
    return d;
  endfunction

  task automatic add_row(input int unsigned count, input logic func, input blink_req_t rq,
                         input bit typed, input display_t want);
    dir_row_t r;
    r.count   = count[7:0];
    r.s.func  = func;
    r.s.rq    = rq;
    r.s.typed = typed;
    r.s.want  = want;
    dir_rows.push_back(r);
  endtask

  task automatic push_word(input logic func, input blink_req_t rq);
    stim_t s;
    s       = '0;
    s.func  = func;
    s.rq    = rq;
    words_to_send.push_back(s);
  endtask

  // Ticks carry random junk in the request fields, which the block must ignore.
  task automatic push_tick();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    push_word(lbps_pkg::FUNC_TICK, junk[REQ_W-1:0]);
  endtask

  task automatic push_random_req(input bit short_timing);
    if (short_timing) begin
      // Short on and off times so that whole patterns play out in a few ticks.
      push_word(lbps_pkg::FUNC_REQ, breq($urandom_range(0, 15), $urandom_range(0, 7),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, 3),
                $urandom_range(0, 6), $urandom_range(0, 6)));
    end else begin
      push_word(lbps_pkg::FUNC_REQ, breq($urandom_range(0, 15), $urandom_range(0, 7),
                $urandom_range(0, 255), $urandom_range(0, 65535),
                $urandom_range(0, 65535)));
    end
  endtask

  task automatic build_stimulus();
    display_t    none;
    int unsigned n_dir;
    int unsigned n;
    none = '0;

    // Directed table. Fields: count, kind of word, request, typed check, result.
    // Idle tick straight after reset: nothing lit, nothing queued.
    add_row(1, lbps_pkg::FUNC_TICK, breq(0, 0, 0, 0, 0), 1,
            disp(0, 0, 0, 0, lbps_pkg::PH_IDLE, 0, 0));
    // One request with one extra blink, one tick on and one tick off.
    add_row(1, lbps_pkg::FUNC_REQ, breq(4'hF, lbps_pkg::KIND_LAYER, 1, 1, 1), 1,
            disp(0, 0, 0, 0, lbps_pkg::PH_IDLE, 1, 0));
    // The tick that starts it lights every LED in the layer colour.
    add_row(1, lbps_pkg::FUNC_TICK, breq(0, 0, 0, 0, 0), 1,
            disp(4'hF, 0, 10, 0, lbps_pkg::PH_ON, 0, 0));
    // Off, on again for the extra blink, off, and back to idle.
    add_row(4, lbps_pkg::FUNC_TICK, breq(0, 0, 0, 0, 0), 0, none);
    // Zero on and off time: the pattern goes dark on the very tick that starts it.
    add_row(1, lbps_pkg::FUNC_REQ, breq(4'h5, lbps_pkg::KIND_BATTERY, 0, 0, 0), 1,
            disp(0, 0, 0, 0, lbps_pkg::PH_IDLE, 1, 0));
    add_row(1, lbps_pkg::FUNC_TICK, breq(0, 0, 0, 0, 0), 1,
            disp(0, 0, 0, 0, lbps_pkg::PH_OFF, 0, 0));
    // Fill the queue with long patterns in the remaining colours and kind 7, then one
    // past full, which is dropped while the display stays as it was.
    add_row(4, lbps_pkg::FUNC_REQ, breq(4'h9, lbps_pkg::KIND_WIRELESS, 255, 65535, 65535),
            0, none);
    add_row(4, lbps_pkg::FUNC_REQ, breq(4'h6, lbps_pkg::KIND_TOUCH_ON, 255, 65535, 65535),
            0, none);
    add_row(4, lbps_pkg::FUNC_REQ, breq(4'hF, lbps_pkg::KIND_TOUCH_OFF, 255, 65535, 65535),
            0, none);
    add_row(4, lbps_pkg::FUNC_REQ, breq(4'h0, 7, 255, 65535, 65535), 0, none);
    add_row(1, lbps_pkg::FUNC_REQ, breq(4'hA, 5, 0, 0, 0), 1,
            disp(0, 0, 0, 0, lbps_pkg::PH_OFF, 16, 1));

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].count) words_to_send.push_back(dir_rows[r].s);
    end
    n_dir = words_to_send.size();

    // Random part, in segments. Most are whole patterns left to play out; some
    // flood the queue past full; the rest is free noise.
    while (words_to_send.size() - n_dir < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
          repeat (n) push_random_req(1);
          n = $urandom_range(2, 40);
          repeat (n) push_tick();
        end
        6, 7: begin
          n = $urandom_range(12, 20);
          repeat (n) push_random_req($urandom_range(0, 1));
          n = $urandom_range(1, 20);
          repeat (n) push_tick();
        end
        default: begin
          n = $urandom_range(5, 30);
          repeat (n) begin
            if ($urandom_range(0, 1) == 0) push_tick();
            else push_random_req($urandom_range(0, 1));
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: words go out in bursts of random length with random gaps between
  // them. Valid stays high across a burst and is only lowered for a real gap.
  // ---------------------------------------------------------------------------
  initial begin : sender
    int unsigned burst_left;
    int unsigned gap;
    stim_t       s;
    burst_left = 0;
    build_stimulus();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    foreach (words_to_send[i]) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      s = words_to_send[i];
      in_tvalid <= 1'b1;
      in_tuser  <= s.func;
      in_tdata  <= IN_W'(s.rq);
      offered   <= s;
      do @(posedge clk); while (!in_tready);
      burst_left--;
    end
    in_tvalid <= 1'b0;

    // Let every outstanding result come back, then a few more cycles so that a
    // stray extra word would still be caught. The extra edge first lets the
    // prediction of the last word land in the queue.
    @(posedge clk);
    while (expected_displays.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready runs of random length broken by short stalls, with a long
  // hold-off now and then so the block fills up and pushes back on its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned run;
    int unsigned next_hold_at;
    next_hold_at = 300;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_seen >= next_hold_at) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        next_hold_at = next_hold_at + 700;
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Hard stop in case the block hangs or loses words.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
